### sv/dbga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbga_pkg: shared types and constants
// Item layout, action and kind codes, gain limits and divider interface.
// ----------------------------------------------------------------------------
package dbga_pkg;

	localparam int RTT_W  = 22;
	localparam int SUM_W  = 38;
	localparam int CNT_W  = 16;
	localparam int DIV_W  = 44;
	localparam int DIV_CW = 6;

	localparam logic [RTT_W-1:0] RTT_MAX    = 22'd3355443;
	localparam logic [31:0]      FLOOR_SEED = 32'h7fffffff;
	localparam logic [CNT_W-1:0] CNT_FULL   = 16'hFFFF;

	localparam logic [10:0] GAIN_MAX    = 11'd1280;
	localparam logic [10:0] GAIN_BASE   = 11'd128;
	localparam logic [5:0]  FACTOR_MIN  = 6'd8;
	localparam logic [5:0]  FACTOR_MAX  = 6'd32;
	localparam logic [5:0]  FACTOR_BASE = 6'd32;
	localparam logic [2:0]  CREDIT_MAX  = 3'd5;

	// input action codes
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_ROUND  = 2'd1;
	localparam logic [1:0] ACT_LOSS   = 2'd2;

	// classified item kinds
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_ROUND  = 2'd2;
	localparam logic [1:0] KIND_LOSS   = 2'd3;

	// configuration register indexes
	localparam logic CFG_SMALL_WIN   = 1'b0;
	localparam logic CFG_GOOD_ROUNDS = 1'b1;

	typedef struct packed {
		logic [1:0]       kind;
		logic             has_rtt;
		logic [RTT_W-1:0] rtt;
		logic [15:0]      acked;
		logic             no_holes;
		logic [15:0]      window;
		logic [31:0]      srtt;
	} item_t;

	typedef struct packed {
		logic             go;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

### sv/dbga_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbga_front: accept and classify
// Clamps the RTT sample, decodes the action and queues items (two deep).
// ----------------------------------------------------------------------------
module dbga_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [23:0]          rtt_us,
	input  logic [15:0]          acked_count,
	input  logic                 no_sack_holes,
	input  logic [15:0]          window,
	input  logic [31:0]          smoothed_rtt,
	output logic                 item_valid,
	input  logic                 item_pop,
	output dbga_pkg::item_t      item
);
	import dbga_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.rtt      = (rtt_us > {2'd0, RTT_MAX}) ? RTT_MAX : rtt_us[RTT_W-1:0];
		cls.has_rtt  = (rtt_us != 24'd0);
		cls.acked    = acked_count;
		cls.no_holes = no_sack_holes;
		cls.window   = window;
		cls.srtt     = smoothed_rtt;
		unique case (action)
			ACT_SAMPLE: cls.kind = cls.has_rtt ? KIND_SAMPLE : KIND_NONE;
			ACT_ROUND:  cls.kind = KIND_ROUND;
			ACT_LOSS:   cls.kind = KIND_LOSS;
			default:    cls.kind = KIND_NONE;
		endcase
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (count_q != 2'd0);
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(item_pop);
		end
	end

endmodule

### sv/dbga_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbga_div: serial divider
// Restoring division, one quotient bit per cycle; done pulses at the end.
// ----------------------------------------------------------------------------
module dbga_div (
	input  logic                clk,
	input  logic                arst_n,
	input  dbga_pkg::div_req_t  req,
	output dbga_pkg::div_rsp_t  rsp
);
	import dbga_pkg::*;

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### sv/dbga_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbga_back: round statistics and gain update
// Sequencer that keeps the round state, drives the divider and loads results.
// ----------------------------------------------------------------------------
module dbga_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_pop,
	input  dbga_pkg::item_t    item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	output dbga_pkg::div_req_t div_req,
	input  dbga_pkg::div_rsp_t div_rsp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [10:0]        add_gain,
	output logic [5:0]         cut_factor,
	output logic [15:0]        reduced_window
);
	import dbga_pkg::*;

	typedef struct packed {
		logic [31:0]      floor;
		logic [31:0]      peak;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic [2:0]       credit;
	} samp_t;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EXEC = 4'd1;
	localparam logic [3:0] ST_AVG  = 4'd2;
	localparam logic [3:0] ST_D1   = 4'd3;
	localparam logic [3:0] ST_D2   = 4'd4;
	localparam logic [3:0] ST_GAIN = 4'd5;
	localparam logic [3:0] ST_X    = 4'd6;
	localparam logic [3:0] ST_GGO  = 4'd7;
	localparam logic [3:0] ST_GDIV = 4'd8;
	localparam logic [3:0] ST_FACT = 4'd9;
	localparam logic [3:0] ST_FDIV = 4'd10;
	localparam logic [3:0] ST_FIN  = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	// rounded-up reciprocals: quotient is the top bits of the product
	localparam logic [31:0] RECIP_100 = 32'h51EB851F;
	localparam logic [31:0] RECIP_10  = 32'hCCCCCCCD;
	localparam logic [31:0] RECIP_19  = 32'hD79435E6;

	function automatic samp_t take_sample(samp_t s, logic [RTT_W-1:0] r,
			logic [15:0] ack, logic nh);
		samp_t       o;
		logic [31:0] r32;
		o   = s;
		r32 = 32'(r);
		if (nh && ack == 16'd1 && s.credit != 3'd0) begin
			if (r32 < s.floor) o.floor = r32;
			o.credit = s.credit - 3'd1;
		end else begin
			if (nh && ack > 16'd1 && s.credit < CREDIT_MAX) o.credit = s.credit + 3'd1;
			if (s.floor == 32'd0 || r32 < s.floor) o.floor = r32;
			if (s.peak < r32) o.peak = r32;
			if (s.count != CNT_FULL) begin
				o.count = s.count + 1'b1;
				o.sum   = s.sum + SUM_W'(r);
			end
		end
		return o;
	endfunction

	logic [3:0]       state_q;
	item_t            item_q;
	logic [15:0]      small_win_q;
	logic [7:0]       good_rounds_q;
	samp_t            samp_q;
	logic [10:0]      gain_q;
	logic [5:0]       factor_q;
	logic             high_q;
	logic [7:0]       low_rounds_q;
	logic [31:0]      dm_q;
	logic [RTT_W-1:0] da_q;
	logic [25:0]      d1_q;
	logic [28:0]      d2_q;
	logic [31:0]      d3_q;
	logic [31:0]      xm_q;
	logic [27:0]      x_q;
	div_req_t         div_q;
	logic             out_valid_q;
	logic [10:0]      add_gain_q;
	logic [5:0]       cut_factor_q;
	logic [15:0]      reduced_window_q;

	samp_t            samp_seed;
	samp_t            samp_smp;
	samp_t            samp_rnd;
	logic [31:0]      avg32;
	logic [31:0]      da32;
	logic [31:0]      dmp;
	logic [RTT_W-1:0] dap;
	logic [31:0]      xnum;
	logic [63:0]      prod100;
	logic [63:0]      prod10;
	logic [63:0]      prod19;
	logic [42:0]      gnum;
	logic [32:0]      gden;
	logic [35:0]      pos;
	logic [35:0]      neg;
	logic [7:0]       lr_inc;
	logic [21:0]      wprod;
	logic [15:0]      wcut;
	logic             load_ok;

	always_comb begin
		samp_seed.floor  = FLOOR_SEED;
		samp_seed.peak   = item_q.srtt;
		samp_seed.sum    = '0;
		samp_seed.count  = '0;
		samp_seed.credit = 3'd0;
		samp_smp = take_sample(samp_q, item_q.rtt, item_q.acked, item_q.no_holes);
		samp_rnd = item_q.has_rtt ?
			take_sample(samp_seed, item_q.rtt, item_q.acked, item_q.no_holes) : samp_seed;
	end

	assign avg32   = 32'(div_rsp.quo[RTT_W-1:0]);
	assign da32    = 32'(da_q);
	assign dmp     = dm_q - 32'(d1_q);
	assign dap     = da_q - RTT_W'(d1_q);
	// da * 1242 / 38 reduces to da * 621 / 19
	assign xnum    = 32'(dap) * 32'd621;
	assign prod100 = 64'(dm_q) * 64'(RECIP_100);
	// one product gives dm / 10 (shift 35) and 8 * dm / 10 (shift 32)
	assign prod10  = 64'(dm_q) * 64'(RECIP_10);
	assign prod19  = 64'(xm_q) * 64'(RECIP_19);
	assign gnum    = 43'(dmp) * 43'd1280;
	assign gden    = 33'(dmp) + 33'(x_q);
	assign pos     = {1'b0, d3_q, 3'b000} + 36'(da_q) * 36'd24;
	assign neg     = {2'b00, d2_q, 5'b00000};
	assign lr_inc  = (low_rounds_q != 8'hFF) ? low_rounds_q + 8'd1 : low_rounds_q;
	assign wprod   = 22'(item_q.window) * 22'(factor_q);
	assign wcut    = item_q.window - wprod[21:6];

	assign load_ok  = !out_valid_q || !out_stall;
	assign item_pop = (state_q == ST_IDLE) && item_valid;

	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_q <= item;
		end
		if (state_q == ST_EXEC) begin
			dm_q <= (samp_q.peak >= samp_q.floor) ? samp_q.peak - samp_q.floor : 32'd0;
		end
		if (state_q == ST_AVG && div_rsp.done) begin
			da_q <= (avg32 >= samp_q.floor) ? RTT_W'(avg32 - samp_q.floor) : '0;
		end
		if (state_q == ST_D1) d1_q <= prod100[62:37];
		if (state_q == ST_D2) begin
			d2_q <= prod10[63:35];
			d3_q <= prod10[63:32];
		end
		if (state_q == ST_GAIN) xm_q <= xnum;
		if (state_q == ST_X)    x_q  <= prod19[63:36];
		if (state_q == ST_OUT && load_ok) begin
			add_gain_q       <= gain_q;
			cut_factor_q     <= factor_q;
			reduced_window_q <= (wcut < 16'd2) ? 16'd2 : wcut;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			small_win_q   <= 16'd15;
			good_rounds_q <= 8'd5;
			samp_q.floor  <= FLOOR_SEED;
			samp_q.peak   <= '0;
			samp_q.sum    <= '0;
			samp_q.count  <= '0;
			samp_q.credit <= '0;
			gain_q        <= GAIN_MAX;
			factor_q      <= FACTOR_BASE;
			high_q        <= 1'b0;
			low_rounds_q  <= '0;
			div_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			div_q.go <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SMALL_WIN:   small_win_q   <= cfg_data;
					CFG_GOOD_ROUNDS: good_rounds_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_OUT;
					unique case (item_q.kind)
						KIND_SAMPLE: samp_q <= samp_smp;
						KIND_LOSS: begin
							gain_q       <= GAIN_BASE;
							factor_q     <= FACTOR_BASE;
							low_rounds_q <= '0;
							high_q       <= 1'b0;
							samp_q.sum   <= '0;
							samp_q.count <= '0;
						end
						KIND_ROUND: begin
							if (item_q.window < small_win_q) begin
								gain_q   <= GAIN_BASE;
								factor_q <= FACTOR_BASE;
								samp_q   <= samp_rnd;
							end else if (samp_q.count != '0) begin
								div_q.go       <= 1'b1;
								div_q.dividend <= DIV_W'(samp_q.sum);
								div_q.divisor  <= DIV_W'(samp_q.count);
								state_q        <= ST_AVG;
							end else begin
								samp_q <= samp_rnd;
							end
						end
						default: ;
					endcase
				end
				ST_AVG: begin
					if (div_rsp.done) state_q <= ST_D1;
				end
				ST_D1: begin
					state_q <= ST_D2;
				end
				ST_D2: begin
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					if (da32 <= 32'(d1_q)) begin
						state_q <= ST_FACT;
						if (!high_q) begin
							gain_q <= GAIN_MAX;
						end else if (lr_inc < good_rounds_q) begin
							low_rounds_q <= lr_inc;
						end else begin
							low_rounds_q <= '0;
							high_q       <= 1'b0;
							gain_q       <= GAIN_MAX;
						end
					end else begin
						high_q  <= 1'b1;
						state_q <= ST_X;
					end
				end
				ST_X: begin
					state_q <= ST_GGO;
				end
				ST_GGO: begin
					div_q.go       <= 1'b1;
					div_q.dividend <= DIV_W'(gnum);
					div_q.divisor  <= DIV_W'(gden);
					state_q        <= ST_GDIV;
				end
				ST_GDIV: begin
					if (div_rsp.done) begin
						gain_q  <= div_rsp.quo[10:0];
						state_q <= ST_FACT;
					end
				end
				ST_FACT: begin
					// pick the clipped cases first, divide only on the slope
					priority if (da32 <= 32'(d2_q)) begin
						factor_q <= FACTOR_MIN;
						state_q  <= ST_FIN;
					end else if (da32 >= d3_q || d3_q <= 32'(d2_q)) begin
						factor_q <= FACTOR_MAX;
						state_q  <= ST_FIN;
					end else if (pos < neg) begin
						factor_q <= 6'd0;
						state_q  <= ST_FIN;
					end else begin
						div_q.go       <= 1'b1;
						div_q.dividend <= DIV_W'(pos - neg);
						div_q.divisor  <= DIV_W'(d3_q - 32'(d2_q));
						state_q        <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (div_rsp.done) begin
						factor_q <= div_rsp.quo[5:0];
						state_q  <= ST_FIN;
					end
				end
				ST_FIN: begin
					samp_q  <= samp_rnd;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign div_req        = div_q;
	assign out_valid      = out_valid_q;
	assign add_gain       = add_gain_q;
	assign cut_factor     = cut_factor_q;
	assign reduced_window = reduced_window_q;

`ifndef ASSERT_OFF
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_q.go |-> !div_rsp.busy)
		else $error("divider started while busy");
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= GAIN_MAX)
		else $error("additive gain out of range");
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		factor_q <= FACTOR_MAX)
		else $error("decrease factor out of range");
	a_credit_range: assert property (@(posedge clk) disable iff (!arst_n)
		samp_q.credit <= CREDIT_MAX)
		else $error("delayed ACK credit out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(add_gain_q))
		else $error("stalled result lost");
`endif

endmodule

### sv/delay_based_gain_adaptation.sv
`timescale 1ns / 1ps
// out_valid rises after the IDLE, EXEC and OUT states for sample, loss and unused items and
// for round ends without samples or with a small window. A round end that adapts also runs
// up to three 44-step divisions on one serial divider before it reaches OUT.
// The back end takes a new item only once it is back in IDLE, and an output stall holds it
// in OUT; a two-deep input queue keeps accepting meanwhile until it is full.
// Reset (asynchronous): maximum additive gain, base decrease factor, empty round, floor seeded; no clearing pass.
// ----------------------------------------------------------------------------
// delay_based_gain_adaptation: top level
// Front queue, back sequencer and shared divider for delay-based gain control.
// ----------------------------------------------------------------------------
module delay_based_gain_adaptation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [23:0] rtt_us,
	input  logic [15:0] acked_count,
	input  logic        no_sack_holes,
	input  logic [15:0] window,
	input  logic [31:0] smoothed_rtt,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] add_gain,
	output logic [5:0]  cut_factor,
	output logic [15:0] reduced_window,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import dbga_pkg::*;

	item_t    item;
	logic     item_valid;
	logic     item_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	dbga_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.rtt_us        (rtt_us),
		.acked_count   (acked_count),
		.no_sack_holes (no_sack_holes),
		.window        (window),
		.smoothed_rtt  (smoothed_rtt),
		.item_valid    (item_valid),
		.item_pop      (item_pop),
		.item          (item)
	);

	dbga_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dbga_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_pop       (item_pop),
		.item           (item),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.div_req        (div_req),
		.div_rsp        (div_rsp),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.add_gain       (add_gain),
		.cut_factor     (cut_factor),
		.reduced_window (reduced_window)
	);

endmodule

### tb/sv/delay_based_gain_adaptation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_based_gain_adaptation_tb: self-checking testbench
// Drives ACK items through the gain adaptation block, predicts every gain,
// factor and reduced window, and compares each transaction in order.
// ----------------------------------------------------------------------------
module delay_based_gain_adaptation_tb;
	import dbga_pkg::*;

	localparam logic [31:0] RTT_LIMIT = 32'd3355443;
	localparam logic [1:0]  ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [10:0] gain;
		logic [5:0]  factor;
		logic [15:0] cut;
	} gains_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [23:0] rtt_us = '0;
	logic [15:0] acked_count = '0;
	logic        no_sack_holes = 1'b0;
	logic [15:0] window = '0;
	logic [31:0] smoothed_rtt = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] add_gain;
	logic [5:0]  cut_factor;
	logic [15:0] reduced_window;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	delay_based_gain_adaptation dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [37:0] sum_q;
	logic [15:0] count_q;
	logic [31:0] floor_q, peak_q;
	logic [10:0] gain_q;
	logic [5:0]  factor_q;
	logic        high_q;
	logic [7:0]  low_q;
	logic [2:0]  credit_q;
	logic [15:0] small_win_q;
	logic [7:0]  good_rounds_q;

	gains_t expected_gains[$];
	int mismatches = 0;
	int hold_off = 0;
	int rx_wait = 0;
	bit rx_random = 1'b1;

	function automatic void add_rtt(logic [31:0] r, logic [15:0] ak, logic nh);
		if (nh) begin
			if (ak == 16'd1 && credit_q != 0) begin
				if (r < floor_q) floor_q = r;
				credit_q = credit_q - 1'b1;
				return;
			end else if (ak > 16'd1 && credit_q < CREDIT_MAX) begin
				credit_q = credit_q + 1'b1;
			end
		end
		if (floor_q == 0 || r < floor_q) floor_q = r;
		if (peak_q < r) peak_q = r;
		if (count_q != 16'hFFFF) begin
			count_q = count_q + 1'b1;
			sum_q = sum_q + 38'(r);
		end
	endfunction

	function automatic logic [10:0] gain_from_delay(logic [63:0] da, logic [63:0] dm);
		logic [63:0] d1;
		d1 = dm / 100;
		if (da <= d1) begin
			if (!high_q) return GAIN_MAX;
			if (low_q != 8'd255) low_q = low_q + 1'b1;
			if (low_q < good_rounds_q) return gain_q;
			low_q = '0;
			high_q = 1'b0;
			return GAIN_MAX;
		end
		high_q = 1'b1;
		dm = dm - d1;
		da = da - d1;
		return 11'((dm * 1280) / (dm + (da * 1242) / 38));
	endfunction

	function automatic logic [5:0] factor_from_delay(logic [63:0] da, logic [63:0] dm);
		logic [63:0] d2, d3, pos, neg;
		d2 = dm / 10;
		if (da <= d2) return FACTOR_MIN;
		d3 = (8 * dm) / 10;
		if (da >= d3 || d3 <= d2) return FACTOR_MAX;
		pos = 8 * d3 + 24 * da;
		neg = 32 * d2;
		if (pos < neg) return 6'd0;
		return 6'((pos - neg) / (d3 - d2));
	endfunction

	function automatic void close_round(logic [15:0] win);
		logic [63:0] avg, dm, da;
		if (win < small_win_q) begin
			gain_q = GAIN_BASE;
			factor_q = FACTOR_BASE;
		end else if (count_q != 0) begin
			avg = 64'(sum_q) / 64'(count_q);
			dm = (peak_q >= floor_q) ? 64'(peak_q - floor_q) : 64'd0;
			da = (avg >= 64'(floor_q)) ? avg - 64'(floor_q) : 64'd0;
			gain_q = gain_from_delay(da, dm);
			factor_q = factor_from_delay(da, dm);
		end
		sum_q = '0;
		count_q = '0;
	endfunction

	function automatic gains_t predict_gains(logic [1:0] act, logic [23:0] r_in,
			logic [15:0] ak, logic nh, logic [15:0] win, logic [31:0] srtt);
		logic [31:0] r, c;
		gains_t g;
		r = (32'(r_in) > RTT_LIMIT) ? RTT_LIMIT : 32'(r_in);
		case (act)
			ACT_SAMPLE: begin
				if (r != 0) add_rtt(r, ak, nh);
			end
			ACT_ROUND: begin
				close_round(win);
				floor_q = FLOOR_SEED;
				peak_q = srtt;
				credit_q = '0;
				if (r != 0) add_rtt(r, ak, nh);
			end
			ACT_LOSS: begin
				gain_q = GAIN_BASE;
				factor_q = FACTOR_BASE;
				low_q = '0;
				high_q = 1'b0;
				sum_q = '0;
				count_q = '0;
			end
			default: ;
		endcase
		c = 32'(win) - ((32'(win) * 32'(factor_q)) >> 6);
		if (c < 2) c = 2;
		g.gain = gain_q;
		g.factor = factor_q;
		g.cut = c[15:0];
		return g;
	endfunction

	// valid stays high after a transaction until the next gap or drain
	task automatic send_ack(logic [1:0] act, logic [23:0] r, logic [15:0] ak, logic nh,
			logic [15:0] win, logic [31:0] srtt, bit gaps = 1);
		int gap;
		gap = gaps ? $urandom_range(0, 8) : 0;
		if (gaps && $urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		rtt_us <= r;
		acked_count <= ak;
		no_sack_holes <= nh;
		window <= win;
		smoothed_rtt <= srtt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_gains.push_back(predict_gains(act, r, ak, nh, win, srtt));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_gains.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SMALL_WIN) small_win_q = val;
		else good_rounds_q = val[7:0];
	endtask

	function automatic logic [23:0] rand_rtt;
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'($urandom);
			2: return 24'($urandom_range(3355400, 3355500));
			default: return 24'($urandom_range(1000, 60000));
		endcase
	endfunction

	task automatic send_random(int n_rounds, int max_len);
		int len;
		for (int k = 0; k < n_rounds; k++) begin
			len = $urandom_range(0, max_len);
			for (int i = 0; i < len; i++)
				send_ack(($urandom_range(0, 19) == 0) ? 2'($urandom) : ACT_SAMPLE,
					rand_rtt(), ($urandom_range(0, 1)) ? 16'($urandom_range(0, 3)) : 16'($urandom),
					1'($urandom), 16'($urandom), $urandom);
			send_ack(ACT_ROUND, rand_rtt(), 16'($urandom_range(0, 3)), 1'($urandom),
				($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom),
				($urandom_range(0, 1)) ? $urandom_range(1000, 90000) : $urandom);
		end
	endtask

	task automatic test_directed;
		send_ack(ACT_SAMPLE, 24'd0, 16'd0, 1'b0, 16'd0, 32'd0);
		send_ack(ACT_SAMPLE, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFFFFFF);
		send_ack(ACT_SAMPLE, 24'd10000, 16'd2, 1'b1, 16'd100, 32'd0);
		send_ack(ACT_SAMPLE, 24'd9000, 16'd1, 1'b1, 16'd100, 32'd0);
		send_ack(ACT_SAMPLE, 24'd50000, 16'd1, 1'b0, 16'd100, 32'd0);
		send_ack(ACT_ROUND, 24'd20000, 16'd3, 1'b1, 16'd200, 32'd60000);
		send_ack(ACT_SAMPLE, 24'd20500, 16'd1, 1'b0, 16'd1, 32'd0);
		send_ack(ACT_ROUND, 24'd0, 16'd0, 1'b0, 16'd1000, 32'd20000);
		send_ack(ACT_ROUND, 24'd0, 16'd0, 1'b0, 16'd1000, 32'd0);
		send_ack(ACT_UNUSED, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFFFFFF);
		send_ack(ACT_ROUND, 24'd500, 16'd0, 1'b1, 16'd3, 32'd0);
		send_ack(ACT_LOSS, 24'd777, 16'd5, 1'b1, 16'd2, 32'd5);
		send_ack(ACT_SAMPLE, 24'd100, 16'd0, 1'b0, 16'd65535, 32'd0);
		send_ack(ACT_ROUND, 24'd3355443, 16'd0, 1'b0, 16'd65535, 32'hFFFFFFFF);
		drain();
	endtask

	// a long round of back-to-back samples, then close it
	task automatic test_long_round;
		for (int i = 0; i < 300; i++)
			send_ack(ACT_SAMPLE, 24'($urandom_range(30000, 40000)), 16'd0, 1'b0,
				16'($urandom), 32'd0, 0);
		send_ack(ACT_ROUND, 24'd35000, 16'd0, 1'b0, 16'd5000, 32'd45000);
		drain();
	endtask

	// congested rounds then quiet rounds exercise the hysteresis
	task automatic test_hysteresis;
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 6; i++)
				send_ack(ACT_SAMPLE, (k < 4) ? 24'($urandom_range(10000, 90000)) : 24'd10000,
					16'd0, 1'b0, 16'd500, 32'd0);
			send_ack(ACT_ROUND, 24'd0, 16'd0, 1'b0, 16'd500, (k < 4) ? 32'd90000 : 32'd10000);
		end
		drain();
	endtask

	task automatic test_random;
		send_random(60, 12);
		drain();
	endtask

	task automatic test_backpressure;
		rx_random = 1'b0;
		hold_off = 200;
		send_random(6, 6);
		rx_random = 1'b1;
		drain();
		repeat (30) @(posedge clk);
		send_random(30, 6);
		drain();
	endtask

	// receiver: after each transaction hold off for a drawn number of cycles
	always @(posedge clk) begin
		int w;
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else if (!rx_random) begin
			out_stall <= 1'b0;
		end else if (out_valid && !out_stall) begin
			w = $urandom_range(0, 8);
			rx_wait <= w;
			out_stall <= (w != 0);
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			out_stall <= (rx_wait > 1);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		gains_t exp_g;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_gains.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction gain=%0d", add_gain);
			end else begin
				exp_g = expected_gains.pop_front();
				if (exp_g.gain !== add_gain || exp_g.factor !== cut_factor ||
						exp_g.cut !== reduced_window) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
							exp_g.gain, exp_g.factor, exp_g.cut,
							add_gain, cut_factor, reduced_window);
				end
			end
		end
	end

	initial begin
		sum_q = '0; count_q = '0; floor_q = FLOOR_SEED; peak_q = '0;
		gain_q = GAIN_MAX; factor_q = FACTOR_BASE; high_q = 1'b0; low_q = '0;
		credit_q = '0; small_win_q = 16'd15; good_rounds_q = 8'd5;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_reg(CFG_SMALL_WIN, 16'd0);
		write_reg(CFG_GOOD_ROUNDS, 16'd0);
		test_hysteresis();
		write_reg(CFG_GOOD_ROUNDS, 16'd255);
		test_hysteresis();
		write_reg(CFG_SMALL_WIN, 16'hFFFF);
		write_reg(CFG_GOOD_ROUNDS, 16'd2);
		test_random();
		write_reg(CFG_SMALL_WIN, 16'd8);
		test_random();
		test_long_round();
		write_reg(CFG_SMALL_WIN, 16'd100);
		write_reg(CFG_GOOD_ROUNDS, 16'd1);
		test_backpressure();
		test_random();
		if (expected_gains.size() != 0) mismatches++;
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
sv/dbga_pkg.sv
sv/dbga_front.sv
sv/dbga_div.sv
sv/dbga_back.sv
sv/delay_based_gain_adaptation.sv
tb/sv/delay_based_gain_adaptation_tb.sv
